// ----- rtl/hte_pkg.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor package
// Shared types, character constants, pattern tables and match functions.
// ----------------------------------------------------------------------------
package hte_pkg;

	// Tag head and entity buffer geometry.
	localparam logic [3:0] TAG_DEPTH = 4'd8;
	localparam logic [2:0] ENT_DEPTH = 3'd5;
	localparam int         MAX_OUT   = 6;
	localparam int         NUM_ENT   = 6;

	// Queue geometry between the front and the back.
	localparam logic [2:0] Q_DEPTH = 3'd4;
	localparam int         Q_AW    = 2;

	// Characters with a role in the parser.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef logic [0:7][7:0] tag_head_t;
	typedef logic [0:3][7:0] ent_buf_t;
	typedef logic [0:3][7:0] ent_name_t;

	// Tag head prefixes, zero padded to the head depth.
	localparam tag_head_t PAT_SCRIPT     = {"script", 8'h00, 8'h00};
	localparam tag_head_t PAT_SCRIPT_END = {"/script", 8'h00};
	localparam tag_head_t PAT_STYLE      = {"style", 8'h00, 8'h00, 8'h00};
	localparam tag_head_t PAT_STYLE_END  = {"/style", 8'h00, 8'h00};

	// Entity names (without the leading ampersand), their lengths and values.
	localparam ent_name_t ENT_NAME [NUM_ENT] = '{
		{"amp", 8'h00},
		{"lt", 8'h00, 8'h00},
		{"gt", 8'h00, 8'h00},
		{"quot"},
		{"#39", 8'h00},
		{"nbsp"}
	};
	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd3, 3'd4};
	localparam logic [7:0] ENT_VAL [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} ent_match_t;

	// One queue entry: the normalized characters caused by one input beat.
	typedef struct packed {
		logic [0:MAX_OUT-1][7:0] chars;
		logic [2:0]              cnt;
	} hte_entry_t;

	function automatic logic [7:0] lc(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	// True when the first n bytes of the tag head equal the pattern.
	function automatic logic head_is(input tag_head_t head, input logic [3:0] len,
			input tag_head_t pat, input logic [3:0] n);
		logic ok;
		ok = (len >= n);
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n && head[3'(i)] != pat[3'(i)])
				ok = 1'b0;
		end
		return ok;
	endfunction

	// Can n buffered name bytes followed by b still begin an entity name?
	function automatic logic ent_extends(input ent_buf_t buf_in, input logic [2:0] n,
			input logic [7:0] b);
		logic hit;
		logic ok;
		hit = 1'b0;
		for (int k = 0; k < NUM_ENT; k++) begin
			ok = (n < 3'd4) && (ENT_LEN[k] > n) && (ENT_NAME[k][n[1:0]] == b);
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < n && ENT_NAME[k][2'(i)] != buf_in[2'(i)])
					ok = 1'b0;
			end
			if (ok)
				hit = 1'b1;
		end
		return hit;
	endfunction

	// Exact match of the n buffered name bytes; the first hit wins.
	function automatic ent_match_t ent_match(input ent_buf_t buf_in, input logic [2:0] n);
		ent_match_t res;
		logic ok;
		res = '0;
		for (int k = NUM_ENT - 1; k >= 0; k--) begin
			ok = (ENT_LEN[k] == n);
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < n && ENT_NAME[k][2'(i)] != buf_in[2'(i)])
					ok = 1'b0;
			end
			if (ok) begin
				res.hit   = 1'b1;
				res.value = ENT_VAL[k];
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/hte_in_if.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor input channel
// Valid/ready channel carrying one document byte and its end-of-document mark.
// ----------------------------------------------------------------------------
interface hte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       doc_end;

	modport source (output valid, output byte_in, output doc_end, input ready);
	modport sink (input valid, input byte_in, input doc_end, output ready);
endinterface

// ----- rtl/hte_out_if.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor output channel
// Valid/ready channel carrying one text byte and its last-of-run mark.
// ----------------------------------------------------------------------------
interface hte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       run_last;

	modport source (output valid, output text_byte, output run_last, input ready);
	modport sink (input valid, input text_byte, input run_last, output ready);
endinterface

// ----- rtl/hte_front.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor front
// Parses one byte per beat and writes its normalized characters to the queue.
// ----------------------------------------------------------------------------
module hte_front (
	input  logic               clk,
	input  logic               arst_n,
	hte_in_if.sink             din,
	input  logic               q_full,
	output logic               push,
	output hte_pkg::hte_entry_t entry
);

	// Progress through a body closer, one bit per matched prefix.
	typedef enum logic [10:0] {
		CP_NONE  = 11'b000_0000_0001,
		CP_LT    = 11'b000_0000_0010,
		CP_SLASH = 11'b000_0000_0100,
		CP_S     = 11'b000_0000_1000,
		CP_SC    = 11'b000_0001_0000,
		CP_SCR   = 11'b000_0010_0000,
		CP_SCRI  = 11'b000_0100_0000,
		CP_SCRIP = 11'b000_1000_0000,
		CP_ST    = 11'b001_0000_0000,
		CP_STY   = 11'b010_0000_0000,
		CP_STYL  = 11'b100_0000_0000
	} cp_t;

	logic               inside_q, inside_n;
	logic               script_q, script_n;
	logic               style_q, style_n;
	hte_pkg::tag_head_t tag_head_q, tag_head_n;
	logic [3:0]         tag_len_q, tag_len_n;
	cp_t                cp_q, cp_n;
	hte_pkg::ent_buf_t  ent_buf_q, ent_buf_n;
	logic [2:0]         ent_len_q, ent_len_n;
	logic               lws_q, lws_n;

	logic                                    accept;
	logic [7:0]                              b, c;
	logic [0:hte_pkg::MAX_OUT-1][7:0]        raw;
	logic [2:0]                              rc;
	logic [2:0]                              n;
	logic                                    fail, plain_b, done_script, done_style;
	hte_pkg::ent_match_t                     em;
	logic [0:hte_pkg::MAX_OUT-1][7:0]        outc;
	logic [2:0]                              oc;
	logic                                    lws;

	assign accept    = din.valid && din.ready;
	assign din.ready = !q_full;
	assign push      = accept && (oc != 3'd0);
	assign entry     = '{chars: outc, cnt: oc};

	always_comb begin
		inside_n    = inside_q;
		script_n    = script_q;
		style_n     = style_q;
		tag_head_n  = tag_head_q;
		tag_len_n   = tag_len_q;
		cp_n        = cp_q;
		ent_buf_n   = ent_buf_q;
		ent_len_n   = ent_len_q;
		raw         = '0;
		rc          = 3'd0;
		fail        = 1'b0;
		plain_b     = 1'b0;
		done_script = 1'b0;
		done_style  = 1'b0;
		em          = '0;
		b           = din.byte_in;
		c           = hte_pkg::lc(din.byte_in);
		n           = ent_len_q - 3'd1;

		if (inside_q) begin
			if (b == hte_pkg::CH_GT) begin
				inside_n = 1'b0;
				if (hte_pkg::head_is(tag_head_q, tag_len_q, hte_pkg::PAT_SCRIPT, 4'd6))
					script_n = 1'b1;
				else if (hte_pkg::head_is(tag_head_q, tag_len_q, hte_pkg::PAT_SCRIPT_END, 4'd7))
					script_n = 1'b0;
				else if (hte_pkg::head_is(tag_head_q, tag_len_q, hte_pkg::PAT_STYLE, 4'd5))
					style_n = 1'b1;
				else if (hte_pkg::head_is(tag_head_q, tag_len_q, hte_pkg::PAT_STYLE_END, 4'd6))
					style_n = 1'b0;
			end else if (tag_len_q < hte_pkg::TAG_DEPTH) begin
				tag_head_n[tag_len_q[2:0]] = c;
				tag_len_n = tag_len_q + 4'd1;
			end
		end else if (script_q || style_q) begin
			cp_n = CP_NONE;
			unique case (cp_q)
				CP_NONE:  if (c == hte_pkg::CH_LT) cp_n = CP_LT;
				CP_LT:    if (c == hte_pkg::CH_SLASH) cp_n = CP_SLASH;
				CP_SLASH: if (c == "s") cp_n = CP_S;
				CP_S: begin
					if (c == "c")
						cp_n = CP_SC;
					else if (c == "t")
						cp_n = CP_ST;
				end
				CP_SC:    if (c == "r") cp_n = CP_SCR;
				CP_SCR:   if (c == "i") cp_n = CP_SCRI;
				CP_SCRI:  if (c == "p") cp_n = CP_SCRIP;
				CP_SCRIP: if (c == "t") done_script = 1'b1;
				CP_ST:    if (c == "y") cp_n = CP_STY;
				CP_STY:   if (c == "l") cp_n = CP_STYL;
				CP_STYL:  if (c == "e") done_style = 1'b1;
				default:  cp_n = CP_NONE;
			endcase
			if (done_script || done_style) begin
				cp_n       = CP_NONE;
				inside_n   = 1'b1;
				raw[rc]    = hte_pkg::CH_SPACE;
				rc         = rc + 3'd1;
				tag_head_n = done_script ? hte_pkg::PAT_SCRIPT_END : hte_pkg::PAT_STYLE_END;
				tag_len_n  = done_script ? 4'd7 : 4'd6;
			end else if (cp_n == CP_NONE && c == hte_pkg::CH_LT) begin
				cp_n = CP_LT;
			end
		end else if (ent_len_q != 3'd0) begin
			if (b == hte_pkg::CH_SEMI) begin
				em = hte_pkg::ent_match(ent_buf_q, n);
				if (em.hit) begin
					ent_len_n = 3'd0;
					raw[rc]   = em.value;
					rc        = rc + 3'd1;
				end else begin
					fail    = 1'b1;
					plain_b = 1'b1;
				end
			end else if (ent_len_q < hte_pkg::ENT_DEPTH
					&& hte_pkg::ent_extends(ent_buf_q, n, b)) begin
				ent_buf_n[n[1:0]] = b;
				ent_len_n = ent_len_q + 3'd1;
			end else begin
				fail    = 1'b1;
				plain_b = 1'b1;
			end
		end else begin
			plain_b = 1'b1;
		end

		// A failed entity replays the ampersand and its buffered name bytes.
		if (fail) begin
			raw[rc] = hte_pkg::CH_AMP;
			rc      = rc + 3'd1;
			for (int i = 0; i < 4; i++) begin
				if (3'(i + 1) < ent_len_q) begin
					raw[rc] = ent_buf_q[2'(i)];
					rc      = rc + 3'd1;
				end
			end
			ent_len_n = 3'd0;
		end

		if (plain_b) begin
			if (b == hte_pkg::CH_LT) begin
				inside_n  = 1'b1;
				tag_len_n = 4'd0;
				raw[rc]   = hte_pkg::CH_SPACE;
				rc        = rc + 3'd1;
			end else if (b == hte_pkg::CH_AMP) begin
				ent_len_n = 3'd1;
			end else begin
				raw[rc] = b;
				rc      = rc + 3'd1;
			end
		end

		// End of document flushes a pending entity, then the state clears.
		if (din.doc_end) begin
			if (ent_len_n != 3'd0) begin
				raw[rc] = hte_pkg::CH_AMP;
				rc      = rc + 3'd1;
				for (int i = 0; i < 4; i++) begin
					if (3'(i + 1) < ent_len_n) begin
						raw[rc] = ent_buf_n[2'(i)];
						rc      = rc + 3'd1;
					end
				end
			end
			inside_n  = 1'b0;
			script_n  = 1'b0;
			style_n   = 1'b0;
			tag_len_n = 4'd0;
			cp_n      = CP_NONE;
			ent_len_n = 3'd0;
		end
	end

	// Normalizer: lowercase, and collapse whitespace runs to one space.
	always_comb begin
		outc = '0;
		oc   = 3'd0;
		lws  = lws_q;
		for (int i = 0; i < hte_pkg::MAX_OUT; i++) begin
			if (3'(i) < rc) begin
				if (hte_pkg::is_ws(raw[3'(i)])) begin
					if (!lws) begin
						outc[oc] = hte_pkg::CH_SPACE;
						oc       = oc + 3'd1;
						lws      = 1'b1;
					end
				end else begin
					outc[oc] = hte_pkg::lc(raw[3'(i)]);
					oc       = oc + 3'd1;
					lws      = 1'b0;
				end
			end
		end
		lws_n = din.doc_end ? 1'b0 : lws;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			script_q  <= 1'b0;
			style_q   <= 1'b0;
			tag_len_q <= 4'd0;
			cp_q      <= CP_NONE;
			ent_len_q <= 3'd0;
			lws_q     <= 1'b0;
		end else if (accept) begin
			inside_q  <= inside_n;
			script_q  <= script_n;
			style_q   <= style_n;
			tag_len_q <= tag_len_n;
			cp_q      <= cp_n;
			ent_len_q <= ent_len_n;
			lws_q     <= lws_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_head_q <= tag_head_n;
			ent_buf_q  <= ent_buf_n;
		end
	end

endmodule

// ----- rtl/hte_queue.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor queue
// Small register FIFO of per-byte result entries between front and back.
// ----------------------------------------------------------------------------
module hte_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hte_pkg::hte_entry_t push_entry,
	output logic                full,
	output logic                head_valid,
	output hte_pkg::hte_entry_t head_entry,
	input  logic                pop
);

	hte_pkg::hte_entry_t             mem_q [int'(hte_pkg::Q_DEPTH)];
	logic [hte_pkg::Q_AW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [2:0]                      count_q;

	assign full       = (count_q == hte_pkg::Q_DEPTH);
	assign head_valid = (count_q != 3'd0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= 3'd0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 3'd1;
			else if (pop && !push)
				count_q <= count_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ----- rtl/hte_back.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor back
// Serializes each queued entry into output beats, one character per beat.
// ----------------------------------------------------------------------------
module hte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  hte_pkg::hte_entry_t head_entry,
	output logic                pop,
	hte_out_if.source           dout
);

	logic [2:0] idx_q;
	logic       last;
	logic       beat;

	assign last           = (idx_q == head_entry.cnt - 3'd1);
	assign beat           = dout.valid && dout.ready;
	assign pop            = beat && last;
	assign dout.valid     = head_valid;
	assign dout.text_byte = head_entry.chars[idx_q];
	assign dout.run_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 3'd0;
		else if (beat)
			idx_q <= last ? 3'd0 : idx_q + 3'd1;
	end

endmodule

// ----- rtl/html_text_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor unit
// Streaming filter that turns HTML bytes into lowercased, space-collapsed text.
// ----------------------------------------------------------------------------
// The unit accepts one document byte per beat on din and can take a new byte
// in every clock cycle. Each byte yields zero to six text bytes on dout; the
// last text byte caused by an input byte carries run_last. The front parses
// the byte in the cycle it is accepted (tags, script and style bodies,
// entities, whitespace collapsing) and writes all of its text bytes as one
// entry into a four-entry queue. The back drains that queue at one output
// beat per cycle while dout.ready is high, one beat per text byte, and
// shows an entry's text once it reaches the queue head. Sustained
// throughput is therefore one input byte per cycle as long as bytes
// average at most one text byte and dout is not stalled; bursts, such as
// a failed entity that replays its buffered name, are absorbed by the queue,
// and din.ready drops only while the queue is full. A byte marked doc_end
// flushes any pending entity and resets the parser for the next document.
module html_text_extractor_unit (
	input  logic      clk,
	input  logic      arst_n,
	hte_in_if.sink    din,
	hte_out_if.source dout
);

	// Entry written by the front for every byte that yields text.
	logic                q_push;
	hte_pkg::hte_entry_t q_push_entry;
	logic                q_full;

	// Oldest entry, read by the back and released after its final beat.
	logic                q_head_valid;
	hte_pkg::hte_entry_t q_head_entry;
	logic                q_pop;

	hte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.q_full (q_full),
		.push   (q_push),
		.entry  (q_push_entry)
	);

	hte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry),
		.pop        (q_pop)
	);

	hte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry),
		.pop        (q_pop),
		.dout       (dout)
	);

endmodule

// ----- tb/html_text_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTML text extractor checker
// Watches both channels, predicts the text of every accepted input beat and
// compares each output beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module html_text_checker (
	input  logic clk,
	input  logic arst_n,
	hte_in_if    din,
	hte_out_if   dout,
	output int   mismatches,
	output int   pending,
	output int   in_beats,
	output int   out_beats,
	output int   docs_done,
	output int   entities_hit,
	output int   closers_hit
);

	localparam int HEAD_MAX = 8;
	localparam int ENT_MAX  = 5;

	// Progress through a possible "</script" or "</style" inside a body.
	typedef enum logic [3:0] {
		CL_NONE, CL_LT, CL_LT_SLASH, CL_S,
		CL_SC, CL_SCR, CL_SCRI, CL_SCRIP,
		CL_ST, CL_STY, CL_STYL
	} closer_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_beat_t;

	logic          in_tag;
	logic          script_on;
	logic          style_on;
	logic          was_space;
	logic [7:0]    head [HEAD_MAX];
	int            head_len;
	closer_state_t closer;
	logic [7:0]    ent_buf [ENT_MAX];
	int            ent_len;
	int            run_len;
	text_beat_t    text_due [$];
	text_beat_t    want;

	function automatic string entity_name(int k);
		case (k)
			0: return "amp";
			1: return "lt";
			2: return "gt";
			3: return "quot";
			4: return "#39";
			5: return "nbsp";
			default: return "";
		endcase
	endfunction

	function automatic logic [7:0] entity_value(int k);
		case (k)
			0: return hte_pkg::CH_AMP;
			1: return hte_pkg::CH_LT;
			2: return hte_pkg::CH_GT;
			3: return 8'h22;
			4: return 8'h27;
			default: return hte_pkg::CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
	endfunction

	function automatic void note_failure(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	// Every produced character goes through here: whitespace runs collapse
	// to one space and capitals are folded to lower case.
	function automatic void put_text(logic [7:0] c);
		if (c == hte_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
			if (!was_space) begin
				text_due.insert(text_due.size(),
					text_beat_t'{ch: hte_pkg::CH_SPACE, last: 1'b0});
				run_len++;
				was_space = 1'b1;
			end
		end else begin
			text_due.insert(text_due.size(), text_beat_t'{ch: to_lower(c), last: 1'b0});
			run_len++;
			was_space = 1'b0;
		end
	endfunction

	function automatic logic head_has(string pat);
		if (head_len < pat.len())
			return 1'b0;
		for (int i = 0; i < pat.len(); i++)
			if (head[i] != pat[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void load_head(string pat);
		for (int i = 0; i < pat.len(); i++)
			head[i] = pat[i];
		head_len = pat.len();
	endfunction

	function automatic void close_tag();
		in_tag = 1'b0;
		if (head_has("script"))
			script_on = 1'b1;
		else if (head_has("/script"))
			script_on = 1'b0;
		else if (head_has("style"))
			style_on = 1'b1;
		else if (head_has("/style"))
			style_on = 1'b0;
	endfunction

	// Can the n buffered name bytes followed by b still begin a known name?
	function automatic logic entity_can_grow(int n, logic [7:0] b);
		string nm;
		logic  ok;
		if (n >= 4)
			return 1'b0;
		for (int k = 0; k < 6; k++) begin
			nm = entity_name(k);
			if (nm.len() <= n)
				continue;
			ok = (nm[n] == b);
			for (int i = 0; i < n; i++)
				if (nm[i] != ent_buf[i + 1])
					ok = 1'b0;
			if (ok)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int entity_lookup(int n);
		string nm;
		logic  ok;
		for (int k = 0; k < 6; k++) begin
			nm = entity_name(k);
			ok = (nm.len() == n);
			for (int i = 0; i < n && ok; i++)
				if (nm[i] != ent_buf[i + 1])
					ok = 1'b0;
			if (ok)
				return k;
		end
		return -1;
	endfunction

	function automatic void replay_entity();
		put_text(hte_pkg::CH_AMP);
		for (int i = 1; i < ent_len; i++)
			put_text(ent_buf[i]);
		ent_len = 0;
	endfunction

	function automatic void plain_char(logic [7:0] b);
		if (b == hte_pkg::CH_LT) begin
			in_tag   = 1'b1;
			head_len = 0;
			put_text(hte_pkg::CH_SPACE);
		end else if (b == hte_pkg::CH_AMP) begin
			ent_buf[0] = hte_pkg::CH_AMP;
			ent_len    = 1;
		end else begin
			put_text(b);
		end
	endfunction

	// Script and style bodies are dropped; only a closer is tracked.
	function automatic void body_char(logic [7:0] b);
		logic [7:0]    c;
		closer_state_t nxt;
		logic          hit_script;
		logic          hit_style;
		c          = to_lower(b);
		nxt        = CL_NONE;
		hit_script = 1'b0;
		hit_style  = 1'b0;
		case (closer)
			CL_NONE:     if (c == hte_pkg::CH_LT) nxt = CL_LT;
			CL_LT:       if (c == hte_pkg::CH_SLASH) nxt = CL_LT_SLASH;
			CL_LT_SLASH: if (c == "s") nxt = CL_S;
			CL_S: begin
				if (c == "c")
					nxt = CL_SC;
				else if (c == "t")
					nxt = CL_ST;
			end
			CL_SC:    if (c == "r") nxt = CL_SCR;
			CL_SCR:   if (c == "i") nxt = CL_SCRI;
			CL_SCRI:  if (c == "p") nxt = CL_SCRIP;
			CL_SCRIP: if (c == "t") hit_script = 1'b1;
			CL_ST:    if (c == "y") nxt = CL_STY;
			CL_STY:   if (c == "l") nxt = CL_STYL;
			CL_STYL:  if (c == "e") hit_style = 1'b1;
			default: ;
		endcase
		if (hit_script || hit_style) begin
			closer = CL_NONE;
			in_tag = 1'b1;
			put_text(hte_pkg::CH_SPACE);
			closers_hit++;
			if (hit_script)
				load_head("/script");
			else
				load_head("/style");
			return;
		end
		if (nxt == CL_NONE && c == hte_pkg::CH_LT)
			nxt = CL_LT;
		closer = nxt;
	endfunction

	function automatic void clear_state();
		in_tag    = 1'b0;
		script_on = 1'b0;
		style_on  = 1'b0;
		was_space = 1'b0;
		head_len  = 0;
		ent_len   = 0;
		closer    = CL_NONE;
		for (int i = 0; i < HEAD_MAX; i++)
			head[i] = 8'h00;
		for (int i = 0; i < ENT_MAX; i++)
			ent_buf[i] = 8'h00;
	endfunction

	// Appends the text beats that one document byte produces.
	function automatic void extract_text(logic [7:0] b, logic last_of_doc);
		int n;
		int k;
		run_len = 0;
		if (in_tag) begin
			if (b == hte_pkg::CH_GT)
				close_tag();
			else if (head_len < HEAD_MAX) begin
				head[head_len] = to_lower(b);
				head_len++;
			end
		end else if (script_on || style_on) begin
			body_char(b);
		end else if (ent_len != 0) begin
			n = ent_len - 1;
			if (b == hte_pkg::CH_SEMI) begin
				k = entity_lookup(n);
				if (k >= 0) begin
					ent_len = 0;
					put_text(entity_value(k));
					entities_hit++;
				end else begin
					replay_entity();
					plain_char(b);
				end
			end else if (ent_len < ENT_MAX && entity_can_grow(n, b)) begin
				ent_buf[ent_len] = b;
				ent_len++;
			end else begin
				replay_entity();
				plain_char(b);
			end
		end else begin
			plain_char(b);
		end
		if (last_of_doc) begin
			if (ent_len != 0)
				replay_entity();
			clear_state();
			docs_done++;
		end
		if (run_len > 0)
			text_due[text_due.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			text_due.delete();
		end else begin
			if (din.valid && din.ready) begin
				in_beats++;
				extract_text(din.byte_in, din.doc_end);
			end
			if (dout.valid && dout.ready) begin
				out_beats++;
				if (text_due.size() == 0) begin
					note_failure($sformatf("unexpected text beat %h run_last %b",
						dout.text_byte, dout.run_last));
				end else begin
					want = text_due.pop_front();
					if (want.ch !== dout.text_byte || want.last !== dout.run_last)
						note_failure($sformatf(
							"text beat %0d: expected %h run_last %b, got %h run_last %b",
							out_beats, want.ch, want.last, dout.text_byte, dout.run_last));
				end
			end
		end
		pending = text_due.size();
	end

endmodule

// ----- tb/tb_html_text_extractor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTML text extractor testbench
// Streams a short directed document and then random HTML built from words,
// whitespace, entities, tags and script or style blocks, with random sender
// gaps and receiver stalls; a checker beside the unit predicts every text beat.
// ----------------------------------------------------------------------------
module tb_html_text_extractor_unit;

	// About 300 random document bytes follow the directed part.
	localparam int RANDOM_BYTES = 300;
	// The watchdog limit lies far beyond the longest quiet stretch of a correct
	// run: any sender gap, receiver stall or the final drain.
	localparam int IDLE_LIMIT   = 2000;

	// One byte of the document stream and its end-of-document mark.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} html_byte_t;

	// Receiver behavior, picked anew at random whenever a phase runs out.
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_BURSTY
	} sink_mode_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       src_valid  = 1'b0;
	logic [7:0] src_byte   = 8'h00;
	logic       src_end    = 1'b0;
	logic       sink_ready = 1'b0;
	sink_mode_t sink_mode  = SINK_OPEN;
	int         phase_left = 0;
	int         stall_left = 0;
	int         idle_cycles = 0;

	int mismatches;
	int pending;
	int in_beats;
	int out_beats;
	int docs_done;
	int entities_hit;
	int closers_hit;

	html_byte_t page [$];

	hte_in_if  din_ch ();
	hte_out_if dout_ch ();

	assign din_ch.valid   = src_valid;
	assign din_ch.byte_in = src_byte;
	assign din_ch.doc_end = src_end;
	assign dout_ch.ready  = sink_ready;

	html_text_extractor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	// The checker sees exactly what the unit sees and reports failures back.
	html_text_checker text_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.din          (din_ch),
		.dout         (dout_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.in_beats     (in_beats),
		.out_beats    (out_beats),
		.docs_done    (docs_done),
		.entities_hit (entities_hit),
		.closers_hit  (closers_hit)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Document building. Every piece is appended to the page queue, and
	// the sender later streams that queue byte by byte.
	// ------------------------------------------------------------------
	function automatic void add_byte(logic [7:0] b, logic last = 1'b0);
		page.insert(page.size(), html_byte_t'{b: b, last: last});
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void mark_doc_end();
		page[page.size() - 1].last = 1'b1;
	endfunction

	// Letters of both cases and digits, the usual content of words and names.
	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 2))
			0:       return 8'(8'h61 + $urandom_range(0, 25));
			1:       return 8'(8'h41 + $urandom_range(0, 25));
			default: return 8'(8'h30 + $urandom_range(0, 9));
		endcase
	endfunction

	// A space or one of the control characters tab through carriage return.
	function automatic logic [7:0] space_char();
		int k;
		k = $urandom_range(0, 5);
		return (k == 0) ? hte_pkg::CH_SPACE : 8'(8'h08 + k);
	endfunction

	function automatic string mixed_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if (r[i] >= 8'h61 && r[i] <= 8'h7A && $urandom_range(0, 1) == 1)
				r[i] = r[i] - 8'd32;
		return r;
	endfunction

	// A complete script or style block. The body mixes ordinary text with
	// pieces that look like the start of a closer, and now and then the
	// block is closed by the other kind of closer.
	function automatic void add_block(string kind);
		string other;
		string nm;
		int    j;
		if (kind == "script")
			other = "style";
		else
			other = "script";
		add_byte(hte_pkg::CH_LT);
		add_str(mixed_case(kind));
		if ($urandom_range(0, 2) == 0)
			add_str(" t=1");
		add_byte(hte_pkg::CH_GT);
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 5))
				0: repeat ($urandom_range(1, 5)) add_byte(word_char());
				1: add_byte(hte_pkg::CH_LT);
				2: add_str("</");
				3: begin
					if ($urandom_range(0, 1) == 1)
						nm = mixed_case(kind);
					else
						nm = mixed_case(other);
					j = $urandom_range(0, nm.len() - 1);
					add_str("</");
					for (int i = 0; i < j; i++)
						add_byte(nm[i]);
				end
				4: add_str("<b>");
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
		add_str("</");
		if ($urandom_range(0, 4) == 0)
			add_str(mixed_case(other));
		else
			add_str(mixed_case(kind));
		if ($urandom_range(0, 2) == 0)
			add_byte(hte_pkg::CH_SPACE);
		add_byte(hte_pkg::CH_GT);
	endfunction

	function automatic void add_random_piece();
		int pick;
		int k;
		int j;
		pick = $urandom_range(0, 99);
		k    = $urandom_range(0, hte_pkg::NUM_ENT - 1);
		if (pick < 22) begin
			// Plain word.
			repeat ($urandom_range(1, 6)) add_byte(word_char());
		end else if (pick < 32) begin
			// Whitespace run.
			repeat ($urandom_range(1, 3)) add_byte(space_char());
		end else if (pick < 45) begin
			// Well-formed entity.
			add_byte(hte_pkg::CH_AMP);
			for (int i = 0; i < hte_pkg::ENT_LEN[k]; i++)
				add_byte(hte_pkg::ENT_NAME[k][i]);
			add_byte(hte_pkg::CH_SEMI);
		end else if (pick < 57) begin
			// Entity that is often broken: a prefix of a known name, or all of it,
			// followed by a byte that may or may not continue or end it.
			j = $urandom_range(0, hte_pkg::ENT_LEN[k]);
			add_byte(hte_pkg::CH_AMP);
			for (int i = 0; i < j; i++)
				add_byte(hte_pkg::ENT_NAME[k][i]);
			case ($urandom_range(0, 4))
				0: add_byte(hte_pkg::CH_SEMI);
				1: add_byte(hte_pkg::CH_LT);
				2: add_byte(hte_pkg::CH_AMP);
				3: add_byte(8'($urandom_range(0, 255)));
				default: add_byte(word_char());
			endcase
		end else if (pick < 69) begin
			// Ordinary tag, sometimes a closing one, sometimes with a name
			// longer than the kept head, sometimes with odd attribute text.
			add_byte(hte_pkg::CH_LT);
			if ($urandom_range(0, 3) == 0)
				add_byte(hte_pkg::CH_SLASH);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(9, 14)) add_byte(word_char());
			else
				repeat ($urandom_range(1, 5)) add_byte(word_char());
			if ($urandom_range(0, 2) == 0)
				add_str(" a=\"&x<\"");
			add_byte(hte_pkg::CH_GT);
		end else if (pick < 79) begin
			add_block("script");
		end else if (pick < 87) begin
			add_block("style");
		end else if (pick < 89) begin
			// Lone tags that only set or clear a flag.
			case ($urandom_range(0, 3))
				0: add_str("</script>");
				1: add_str("</style>");
				2: add_str("<STYLE>");
				default: add_str("<script>");
			endcase
		end else if (pick < 93) begin
			// Noise over the whole byte range.
			add_byte(8'($urandom_range(0, 255)));
		end else if (page.size() != 0 && $urandom_range(0, 1) == 1) begin
			// End of document on whatever came last.
			mark_doc_end();
		end else begin
			// End of document with an entity still pending.
			j = $urandom_range(0, hte_pkg::ENT_LEN[k]);
			add_byte(hte_pkg::CH_AMP);
			for (int i = 0; i < j; i++)
				add_byte(hte_pkg::ENT_NAME[k][i]);
			mark_doc_end();
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver: ready follows a mode that is picked anew at random for each
	// phase, from always ready through random stalls to long stall runs.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (phase_left == 0) begin
			sink_mode  <= sink_mode_t'($urandom_range(0, 2));
			phase_left <= $urandom_range(30, 150);
		end else begin
			phase_left <= phase_left - 1;
		end
		if (stall_left != 0) begin
			sink_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (sink_mode)
				SINK_OPEN:   sink_ready <= 1'b1;
				SINK_RANDOM: sink_ready <= ($urandom_range(0, 2) != 0);
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						sink_ready <= 1'b0;
						stall_left <= $urandom_range(2, 14);
					end else begin
						sink_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run when no beat moves on either channel for
	// too long.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (src_valid && din_ch.ready) || (dout_ch.valid && sink_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles, %0d text beats still due.",
				IDLE_LIMIT, pending);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and verdict.
	// ------------------------------------------------------------------
	initial begin
		int idx;
		int burst;
		int gap;

		// Directed opening: the extreme byte values, a capital, a whitespace
		// run, a decoded entity, a failed entity that ends by opening a tag,
		// a style tag, a script closer inside the style body (which leaves
		// style active), and a document end inside a body.
		add_byte(8'hFF);
		add_str("A\t ");
		add_str("&lt;");
		add_str("&#3<");
		add_str("STYLE>");
		add_str("</Script>");
		add_byte(8'h00, 1'b1);

		while (page.size() < 24 + RANDOM_BYTES)
			add_random_piece();
		mark_doc_end();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The sender works in bursts. Most bursts are short with short gaps,
		// and about one in five is a long stretch that never idles, so gaps
		// land on every phase of the unit's work.
		idx = 0;
		while (idx < page.size()) begin
			if ($urandom_range(0, 4) == 0)
				burst = $urandom_range(20, 60);
			else
				burst = $urandom_range(1, 8);
			for (int j = 0; j < burst && idx < page.size(); j++) begin
				src_valid <= 1'b1;
				src_byte  <= page[idx].b;
				src_end   <= page[idx].last;
				// Hold the beat until the unit takes it.
				do
					@(posedge clk);
				while (!din_ch.ready);
				idx++;
			end
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		src_valid <= 1'b0;

		// Let every predicted text beat drain, then watch a little longer
		// for any stray beat the unit might still send.
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("Run covered %0d input beats over %0d documents and %0d text beats out.",
			in_beats, docs_done, out_beats);
		$display("It decoded %0d entities, met %0d body closers and found %0d mismatches.",
			entities_hit, closers_hit, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/hte_pkg.sv
rtl/hte_in_if.sv
rtl/hte_out_if.sv
rtl/hte_front.sv
rtl/hte_queue.sv
rtl/hte_back.sv
rtl/html_text_extractor_unit.sv
tb/html_text_checker.sv
tb/tb_html_text_extractor_unit.sv
